>>> rtl/core/xxhash64_stream_hasher_macros.svh
// Assertion macros shared by the hasher's RTL.
`ifndef XXHASH64_STREAM_HASHER_MACROS_SVH
`define XXHASH64_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XXH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define XXH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/xxh_pkg.sv
package xxh_pkg;

    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_FOLD1, S_FOLD2, S_FOLDEND, S_INIT,
        S_MG1, S_MG2, S_MG3, S_ADDLEN, S_TW1, S_TW2, S_TW3,
        S_T4A, S_T4B, S_TB1, S_TB2, S_AV1, S_AV2, S_EMIT
    } state_t;

    // Multiplier operand sources.
    typedef enum logic [3:0] {
        XS_BUF, XS_LANE, XS_LANE_ROT, XS_M_ROT31, XS_H, XS_H_ROT27,
        XS_WORD_LO, XS_H_ROT23, XS_BYTE, XS_H_ROT11, XS_AVA33, XS_AVA29
    } xsel_t;

    typedef enum logic [2:0] {
        KS_P1, KS_P2, KS_P3, KS_P5
    } ksel_t;

    // Updates of the hash accumulator; the product-based ones are applied when the product is ready.
    typedef enum logic [2:0] {
        H_NONE, H_INIT, H_XOR_M, H_M_P4, H_M_P3, H_M, H_ADD_LEN
    } hop_t;

    typedef struct packed {
        logic       in_ready;
        logic       mul_go;
        xsel_t      xsel;
        ksel_t      ksel;
        hop_t       hop;
        logic       lane_wr;
        logic       fold_end;
        logic       out_load;
        logic       clear;
        logic [2:0] idx;
    } cmd_t;

    typedef struct packed {
        logic       mul_done;
        logic       pending_fold;
        logic       is_last;
        logic       stripe_seen;
        logic [1:0] words;
        logic [3:0] cnt;
        logic       out_blocked;
        logic       in_valid;
    } sts_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
        return (v << s) | (v >> (64 - s));
    endfunction

endpackage

>>> rtl/core/xxh_stream_if.sv
interface xxh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        is_last;

    modport source (output valid, output data_word, output byte_count, output is_last,
                    input ready);
    modport sink (input valid, input data_word, input byte_count, input is_last,
                  output ready);
endinterface

interface xxh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface

>>> rtl/core/xxhash64_stream_hasher.sv
// xxHash64 (seed 0) over a stream of little-endian 64-bit words, one message at a time.
// Every multiply goes through the shared 64-bit unit; it is the only arithmetic loop.
// A word that completes a 32-byte stripe first folds the stripe into the four lanes.
// The last word then runs the lane merge once a stripe was folded, adds the length,
// and mixes in the buffered words, a 4-byte chunk and the tail bytes, then avalanches.
// rst_n is asynchronous, active low; it restores the initial lanes and empties the output.
`include "xxhash64_stream_hasher_macros.svh"

module xxhash64_stream_hasher
(
    input  logic      clk,
    input  logic      rst_n,
    xxh_in_if.sink    in_ch,
    xxh_out_if.source out_ch
);

    // The controller sequences every step of the hash through one shared multiplier
    // in the datapath. Input transactions are taken only while the controller is
    // idle. The finished hash sits in an output register, so a new message can start
    // while the previous hash still waits to be taken; only the next hash stalls.
    xxh_pkg::cmd_t cmd;
    xxh_pkg::sts_t sts;

    xxh_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    xxh_datapath u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .sts    (sts)
    );

    // After an accepted transaction the controller must leave idle to process it.
    `XXH_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "busy")
    // A multiply is never started twice in a row.
    `XXH_ASSERT_NEXT(a_single_issue, cmd.mul_go, !cmd.mul_go, "back-to-back multiply issue")
    // A hash is loaded only when the output register is free or being drained.
    `XXH_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(out_ch.valid && !out_ch.ready), "overwrite")

endmodule

>>> rtl/core/xxh_mul.sv
module xxh_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    // Low 64 bits of a 64x64 product from three 32x32 partial products.
    logic [1:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [31:0] opa, opb;
    logic [63:0] pp;

    always_comb
    begin
        opa = a_reg[31:0];
        opb = b_reg[31:0];
        case (step_reg)
            2'd2:    opb = b_reg[63:32];
            2'd3:    opa = a_reg[63:32];
            default: ;
        endcase
        pp = opa * opb;
    end

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        case (step_reg)
            2'd0:
            begin
                if (start)
                begin
                    step_next = 2'd1;
                end
            end
            2'd1:
            begin
                acc_next  = pp;
                step_next = 2'd2;
            end
            2'd2:
            begin
                acc_next  = acc_reg + {pp[31:0], 32'd0};
                step_next = 2'd3;
            end
            default:
            begin
                acc_next  = acc_reg + {pp[31:0], 32'd0};
                step_next = 2'd0;
                done_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && step_reg == 2'd0)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

>>> rtl/core/xxh_datapath.sv
module xxh_datapath
(
    input  logic          clk,
    input  logic          rst_n,
    xxh_in_if.sink        in_ch,
    xxh_out_if.source     out_ch,
    input  xxh_pkg::cmd_t cmd,
    output xxh_pkg::sts_t sts
);

    logic [63:0] lane_reg [4];
    logic [63:0] lane_next [4];
    logic [63:0] buf_reg [4];
    logic [1:0]  words_reg, words_next;
    logic [63:0] total_reg, total_next;
    logic        seen_reg, seen_next;
    logic        fold_reg, fold_next;
    logic        last_reg, last_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] word_reg;
    logic [63:0] h_reg, h_next;
    logic        oval_reg, oval_next;
    logic [63:0] hash_reg;

    logic        accept, push;
    logic [3:0]  sat_cnt;
    logic [1:0]  li;
    logic [63:0] x, k, m;
    logic        mdone;
    logic [63:0] conv;

    assign accept  = in_ch.valid && in_ch.ready;
    assign sat_cnt = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
    assign push    = !in_ch.is_last || sat_cnt == 4'd8;
    assign li      = cmd.idx[1:0];

    assign conv = xxh_pkg::rotl64(lane_reg[0], 1) + xxh_pkg::rotl64(lane_reg[1], 7)
                + xxh_pkg::rotl64(lane_reg[2], 12) + xxh_pkg::rotl64(lane_reg[3], 18);

    always_comb
    begin
        case (cmd.xsel)
            xxh_pkg::XS_BUF:      x = buf_reg[li];
            xxh_pkg::XS_LANE:     x = lane_reg[li];
            xxh_pkg::XS_LANE_ROT: x = xxh_pkg::rotl64(lane_reg[li] + m, 31);
            xxh_pkg::XS_M_ROT31:  x = xxh_pkg::rotl64(m, 31);
            xxh_pkg::XS_H:        x = h_reg;
            xxh_pkg::XS_H_ROT27:  x = xxh_pkg::rotl64(h_reg, 27);
            xxh_pkg::XS_WORD_LO:  x = {32'd0, word_reg[31:0]};
            xxh_pkg::XS_H_ROT23:  x = xxh_pkg::rotl64(h_reg, 23);
            xxh_pkg::XS_BYTE:     x = {56'd0, word_reg[{cmd.idx, 3'b000} +: 8]};
            xxh_pkg::XS_H_ROT11:  x = xxh_pkg::rotl64(h_reg, 11);
            xxh_pkg::XS_AVA33:    x = h_reg ^ (h_reg >> 33);
            xxh_pkg::XS_AVA29:    x = m ^ (m >> 29);
            default:              x = h_reg;
        endcase
        case (cmd.ksel)
            xxh_pkg::KS_P1: k = xxh_pkg::P1;
            xxh_pkg::KS_P2: k = xxh_pkg::P2;
            xxh_pkg::KS_P3: k = xxh_pkg::P3;
            default:        k = xxh_pkg::P5;
        endcase
    end

    xxh_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_go),
        .a     (x),
        .b     (k),
        .done  (mdone),
        .p     (m)
    );

    always_comb
    begin
        lane_next  = lane_reg;
        words_next = words_reg;
        total_next = total_reg;
        seen_next  = seen_reg;
        fold_next  = fold_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        h_next     = h_reg;
        oval_next  = oval_reg && !out_ch.ready;

        if (accept)
        begin
            total_next = total_reg + (in_ch.is_last ? {60'd0, sat_cnt} : 64'd8);
            last_next  = in_ch.is_last;
            cnt_next   = push ? 4'd0 : sat_cnt;
            fold_next  = push && words_reg == 2'd3;
            if (push)
            begin
                words_next = words_reg + 2'd1;
            end
        end
        if (cmd.lane_wr)
        begin
            lane_next[li] = m;
        end
        if (cmd.fold_end)
        begin
            words_next = 2'd0;
            seen_next  = 1'b1;
            fold_next  = 1'b0;
        end
        case (cmd.hop)
            xxh_pkg::H_INIT:    h_next = seen_reg ? conv : xxh_pkg::P5;
            xxh_pkg::H_XOR_M:   h_next = h_reg ^ m;
            xxh_pkg::H_M_P4:    h_next = m + xxh_pkg::P4;
            xxh_pkg::H_M_P3:    h_next = m + xxh_pkg::P3;
            xxh_pkg::H_M:       h_next = m;
            xxh_pkg::H_ADD_LEN: h_next = h_reg + total_reg;
            default:            ;
        endcase
        if (cmd.out_load)
        begin
            oval_next = 1'b1;
        end
        if (cmd.clear)
        begin
            lane_next[0] = xxh_pkg::P1 + xxh_pkg::P2;
            lane_next[1] = xxh_pkg::P2;
            lane_next[2] = 64'd0;
            lane_next[3] = 64'd0 - xxh_pkg::P1;
            words_next   = 2'd0;
            total_next   = 64'd0;
            seen_next    = 1'b0;
            fold_next    = 1'b0;
            last_next    = 1'b0;
            cnt_next     = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg[0] <= xxh_pkg::P1 + xxh_pkg::P2;
            lane_reg[1] <= xxh_pkg::P2;
            lane_reg[2] <= 64'd0;
            lane_reg[3] <= 64'd0 - xxh_pkg::P1;
            words_reg   <= 2'd0;
            total_reg   <= 64'd0;
            seen_reg    <= 1'b0;
            fold_reg    <= 1'b0;
            last_reg    <= 1'b0;
            cnt_reg     <= 4'd0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            lane_reg  <= lane_next;
            words_reg <= words_next;
            total_reg <= total_next;
            seen_reg  <= seen_next;
            fold_reg  <= fold_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        if (accept)
        begin
            word_reg <= in_ch.data_word;
            if (push)
            begin
                buf_reg[words_reg] <= in_ch.data_word;
            end
        end
        if (cmd.out_load)
        begin
            hash_reg <= m ^ (m >> 32);
        end
    end

    assign in_ch.ready       = cmd.in_ready;
    assign out_ch.valid      = oval_reg;
    assign out_ch.hash_value = hash_reg;

    assign sts.mul_done     = mdone;
    assign sts.pending_fold = fold_reg;
    assign sts.is_last      = last_reg;
    assign sts.stripe_seen  = seen_reg;
    assign sts.words        = words_reg;
    assign sts.cnt          = cnt_reg;
    assign sts.out_blocked  = oval_reg && !out_ch.ready;
    assign sts.in_valid     = in_ch.valid;

endmodule

>>> rtl/core/xxh_ctrl.sv
module xxh_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  xxh_pkg::sts_t sts,
    output xxh_pkg::cmd_t cmd
);

    xxh_pkg::state_t state_reg, state_next;
    logic [2:0]      idx_reg, idx_next;
    logic            issued_reg, issued_next;
    logic            is_mul, fin;
    xxh_pkg::state_t tail_state;

    always_comb
    begin
        case (state_reg)
            xxh_pkg::S_FOLD1, xxh_pkg::S_FOLD2, xxh_pkg::S_MG1, xxh_pkg::S_MG2,
            xxh_pkg::S_MG3, xxh_pkg::S_TW1, xxh_pkg::S_TW2, xxh_pkg::S_TW3,
            xxh_pkg::S_T4A, xxh_pkg::S_T4B, xxh_pkg::S_TB1, xxh_pkg::S_TB2,
            xxh_pkg::S_AV1, xxh_pkg::S_AV2: is_mul = 1'b1;
            default:                         is_mul = 1'b0;
        endcase
    end

    // A multiply state finishes on the cycle its product arrives.
    assign fin = is_mul && issued_reg && sts.mul_done;

    always_comb
    begin
        if (sts.cnt >= 4'd4)
        begin
            tail_state = xxh_pkg::S_T4A;
        end
        else if (sts.cnt != 4'd0)
        begin
            tail_state = xxh_pkg::S_TB1;
        end
        else
        begin
            tail_state = xxh_pkg::S_AV1;
        end
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        issued_next = is_mul && !fin;
        case (state_reg)
            xxh_pkg::S_IDLE:
            begin
                idx_next = 3'd0;
                // Ready is high in idle, so a valid input is accepted this cycle.
                if (sts.in_valid)
                begin
                    state_next = xxh_pkg::S_DISPATCH;
                end
            end
            xxh_pkg::S_DISPATCH:
            begin
                idx_next = 3'd0;
                if (sts.pending_fold)
                begin
                    state_next = xxh_pkg::S_FOLD1;
                end
                else if (sts.is_last)
                begin
                    state_next = xxh_pkg::S_INIT;
                end
                else
                begin
                    state_next = xxh_pkg::S_IDLE;
                end
            end
            xxh_pkg::S_FOLD1:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_FOLD2;
                end
            end
            xxh_pkg::S_FOLD2:
            begin
                if (fin)
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = (idx_reg == 3'd3) ? xxh_pkg::S_FOLDEND : xxh_pkg::S_FOLD1;
                end
            end
            xxh_pkg::S_FOLDEND:
            begin
                idx_next   = 3'd0;
                state_next = sts.is_last ? xxh_pkg::S_INIT : xxh_pkg::S_IDLE;
            end
            xxh_pkg::S_INIT:
            begin
                idx_next   = 3'd0;
                state_next = sts.stripe_seen ? xxh_pkg::S_MG1 : xxh_pkg::S_ADDLEN;
            end
            xxh_pkg::S_MG1:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_MG2;
                end
            end
            xxh_pkg::S_MG2:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_MG3;
                end
            end
            xxh_pkg::S_MG3:
            begin
                if (fin)
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = (idx_reg == 3'd3) ? xxh_pkg::S_ADDLEN : xxh_pkg::S_MG1;
                end
            end
            xxh_pkg::S_ADDLEN:
            begin
                idx_next   = 3'd0;
                state_next = (sts.words != 2'd0) ? xxh_pkg::S_TW1 : tail_state;
            end
            xxh_pkg::S_TW1:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_TW2;
                end
            end
            xxh_pkg::S_TW2:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_TW3;
                end
            end
            xxh_pkg::S_TW3:
            begin
                if (fin)
                begin
                    if (idx_reg[1:0] + 2'd1 == sts.words)
                    begin
                        idx_next   = 3'd0;
                        state_next = tail_state;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = xxh_pkg::S_TW1;
                    end
                end
            end
            xxh_pkg::S_T4A:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_T4B;
                end
            end
            xxh_pkg::S_T4B:
            begin
                if (fin)
                begin
                    idx_next   = 3'd4;
                    state_next = (sts.cnt > 4'd4) ? xxh_pkg::S_TB1 : xxh_pkg::S_AV1;
                end
            end
            xxh_pkg::S_TB1:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_TB2;
                end
            end
            xxh_pkg::S_TB2:
            begin
                if (fin)
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ({1'b0, idx_reg} + 4'd1 == sts.cnt) ? xxh_pkg::S_AV1
                                                                     : xxh_pkg::S_TB1;
                end
            end
            xxh_pkg::S_AV1:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_AV2;
                end
            end
            xxh_pkg::S_AV2:
            begin
                if (fin)
                begin
                    state_next = xxh_pkg::S_EMIT;
                end
            end
            xxh_pkg::S_EMIT:
            begin
                if (!sts.out_blocked)
                begin
                    state_next = xxh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = xxh_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.xsel     = xxh_pkg::XS_H;
        cmd.ksel     = xxh_pkg::KS_P1;
        cmd.hop      = xxh_pkg::H_NONE;
        cmd.idx      = idx_reg;
        cmd.mul_go   = is_mul && !issued_reg;
        case (state_reg)
            xxh_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            xxh_pkg::S_FOLD1:
            begin
                cmd.xsel = xxh_pkg::XS_BUF;
                cmd.ksel = xxh_pkg::KS_P2;
            end
            xxh_pkg::S_FOLD2:
            begin
                cmd.xsel    = xxh_pkg::XS_LANE_ROT;
                cmd.lane_wr = fin;
            end
            xxh_pkg::S_FOLDEND:
            begin
                cmd.fold_end = 1'b1;
            end
            xxh_pkg::S_INIT:
            begin
                cmd.hop = xxh_pkg::H_INIT;
            end
            xxh_pkg::S_MG1:
            begin
                cmd.xsel = xxh_pkg::XS_LANE;
                cmd.ksel = xxh_pkg::KS_P2;
            end
            xxh_pkg::S_MG2:
            begin
                cmd.xsel = xxh_pkg::XS_M_ROT31;
                cmd.hop  = fin ? xxh_pkg::H_XOR_M : xxh_pkg::H_NONE;
            end
            xxh_pkg::S_MG3:
            begin
                cmd.xsel = xxh_pkg::XS_H;
                cmd.hop  = fin ? xxh_pkg::H_M_P4 : xxh_pkg::H_NONE;
            end
            xxh_pkg::S_ADDLEN:
            begin
                cmd.hop = xxh_pkg::H_ADD_LEN;
            end
            xxh_pkg::S_TW1:
            begin
                cmd.xsel = xxh_pkg::XS_BUF;
                cmd.ksel = xxh_pkg::KS_P2;
            end
            xxh_pkg::S_TW2:
            begin
                cmd.xsel = xxh_pkg::XS_M_ROT31;
                cmd.hop  = fin ? xxh_pkg::H_XOR_M : xxh_pkg::H_NONE;
            end
            xxh_pkg::S_TW3:
            begin
                cmd.xsel = xxh_pkg::XS_H_ROT27;
                cmd.hop  = fin ? xxh_pkg::H_M_P4 : xxh_pkg::H_NONE;
            end
            xxh_pkg::S_T4A:
            begin
                cmd.xsel = xxh_pkg::XS_WORD_LO;
                cmd.hop  = fin ? xxh_pkg::H_XOR_M : xxh_pkg::H_NONE;
            end
            xxh_pkg::S_T4B:
            begin
                cmd.xsel = xxh_pkg::XS_H_ROT23;
                cmd.ksel = xxh_pkg::KS_P2;
                cmd.hop  = fin ? xxh_pkg::H_M_P3 : xxh_pkg::H_NONE;
            end
            xxh_pkg::S_TB1:
            begin
                cmd.xsel = xxh_pkg::XS_BYTE;
                cmd.ksel = xxh_pkg::KS_P5;
                cmd.hop  = fin ? xxh_pkg::H_XOR_M : xxh_pkg::H_NONE;
            end
            xxh_pkg::S_TB2:
            begin
                cmd.xsel = xxh_pkg::XS_H_ROT11;
                cmd.hop  = fin ? xxh_pkg::H_M : xxh_pkg::H_NONE;
            end
            xxh_pkg::S_AV1:
            begin
                cmd.xsel = xxh_pkg::XS_AVA33;
                cmd.ksel = xxh_pkg::KS_P2;
            end
            xxh_pkg::S_AV2:
            begin
                cmd.xsel = xxh_pkg::XS_AVA29;
                cmd.ksel = xxh_pkg::KS_P3;
            end
            xxh_pkg::S_EMIT:
            begin
                cmd.out_load = !sts.out_blocked;
                cmd.clear    = !sts.out_blocked;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= xxh_pkg::S_IDLE;
            idx_reg    <= 3'd0;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            issued_reg <= issued_next;
        end
    end

endmodule

>>> dv/xxh_tb_if.sv
`timescale 1ns / 100ps

// Testbench copy of the channel interfaces is not needed; the RTL interfaces are reused.
// This file holds the stimulus item type shared by the testbench.
package xxh_tb_pkg;

    typedef struct {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        is_last;
    } word_item_t;

endpackage

>>> dv/xxhash64_stream_hasher_tb.sv
`timescale 1ns / 100ps

module xxhash64_stream_hasher_tb;

    // Digest predictor and store of pending digests. The predictor keeps its own copy
    // of the lane accumulators, the partial stripe and the running message length.
    class digest_board;
        logic [63:0] lanes [4];
        logic [63:0] stripe [4];
        int unsigned held_bytes;
        logic [63:0] msg_len;
        bit          folded;
        logic [63:0] pending_digests [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            lanes[0] = xxh_pkg::P1 + xxh_pkg::P2;
            lanes[1] = xxh_pkg::P2;
            lanes[2] = 64'd0;
            lanes[3] = 64'd0 - xxh_pkg::P1;
            held_bytes = 0;
            msg_len = 64'd0;
            folded = 1'b0;
        endfunction

        function logic [63:0] rol(logic [63:0] v, int s);
            return (v << s) | (v >> (64 - s));
        endfunction

        function logic [63:0] lane_mix(logic [63:0] a, logic [63:0] w);
            a = a + w * xxh_pkg::P2;
            return rol(a, 31) * xxh_pkg::P1;
        endfunction

        function void add_word(logic [63:0] w);
            int slot;
            slot = held_bytes / 8;
            stripe[slot] = w;
            held_bytes += 8;
            if (slot == 3)
            begin
                for (int i = 0; i < 4; i++)
                    lanes[i] = lane_mix(lanes[i], stripe[i]);
                held_bytes = 0;
                folded = 1'b1;
            end
        endfunction

        // Called for every accepted input transaction.
        function void note_word(xxh_tb_pkg::word_item_t it);
            logic [63:0] h;
            int cnt;
            int pos;
            if (!it.is_last)
            begin
                msg_len += 64'd8;
                add_word(it.data_word);
                return;
            end
            cnt = (it.byte_count > 8) ? 8 : it.byte_count;
            msg_len += 64'(cnt);
            if (cnt == 8)
            begin
                add_word(it.data_word);
                cnt = 0;
            end
            if (folded)
            begin
                h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
                for (int i = 0; i < 4; i++)
                begin
                    h ^= lane_mix(64'd0, lanes[i]);
                    h = h * xxh_pkg::P1 + xxh_pkg::P4;
                end
            end
            else
                h = xxh_pkg::P5;
            h += msg_len;
            for (int i = 0; i < held_bytes / 8; i++)
            begin
                h ^= lane_mix(64'd0, stripe[i]);
                h = rol(h, 27) * xxh_pkg::P1 + xxh_pkg::P4;
            end
            pos = 0;
            if (cnt >= 4)
            begin
                h ^= {32'd0, it.data_word[31:0]} * xxh_pkg::P1;
                h = rol(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
                pos = 4;
            end
            for (; pos < cnt; pos++)
            begin
                h ^= {56'd0, it.data_word[8*pos +: 8]} * xxh_pkg::P5;
                h = rol(h, 11) * xxh_pkg::P1;
            end
            h ^= h >> 33;
            h *= xxh_pkg::P2;
            h ^= h >> 29;
            h *= xxh_pkg::P3;
            h ^= h >> 32;
            pending_digests.push_back(h);
            restart();
        endfunction

        // Called for every accepted output transaction.
        function void check_digest(logic [63:0] got);
            logic [63:0] want;
            if (pending_digests.size() == 0)
            begin
                $display("%0t: unexpected digest, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_digests.pop_front();
            if (want !== got)
            begin
                $display("%0t: hash_value mismatch, expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    xxh_in_if  in_ch ();
    xxh_out_if out_ch ();

    xxhash64_stream_hasher uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    digest_board board;
    int          send_idle_pct;
    int          recv_idle_pct;
    longint      cycle_count;
    bit          stim_done;

    // A message may be 41 words long, with the sender and receiver idling; the
    // watchdog limit is far beyond the slowest correct run.
    localparam longint CYCLE_LIMIT = 64'd1000000;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Cycle counter acting as a watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random; every accepted output transaction is checked
    // against the oldest pending digest. Sampling happens at the clock edge, before
    // the nonblocking updates of that edge take effect.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_digest(out_ch.hash_value);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Drives one input transaction and holds it until accepted. The sender may
    // idle before offering it. valid stays high between back-to-back items.
    task automatic send_word(xxh_tb_pkg::word_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_word  <= it.data_word;
        in_ch.byte_count <= it.byte_count;
        in_ch.is_last    <= it.is_last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_word(it);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Sends a message of the given number of full words and a last item with
    // the given count. A non-last item may carry any byte_count, which the block
    // must treat as eight bytes.
    task automatic send_message(int full_words, logic [3:0] tail_count, logic [63:0] fill);
        xxh_tb_pkg::word_item_t it;
        for (int i = 0; i < full_words; i++)
        begin
            it.data_word  = (fill == 64'd1) ? rand_word() : fill;
            it.byte_count = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
            it.is_last    = 1'b0;
            send_word(it);
        end
        it.data_word  = (fill == 64'd1) ? rand_word() : fill;
        it.byte_count = tail_count;
        it.is_last    = 1'b1;
        send_word(it);
    endtask

    task automatic random_phase(int items);
        int sent;
        int words;
        sent = 0;
        while (sent < items)
        begin
            // Mostly short messages, now and then one spanning several stripes.
            words = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(9);
            send_message(words, 4'($urandom_range(15)), 64'd1);
            sent += words + 1;
        end
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        stim_done     = 1'b0;
        cycle_count   = 0;
        send_idle_pct = 21;
        recv_idle_pct = 75;
        in_ch.valid      = 1'b0;
        in_ch.data_word  = 64'd0;
        in_ch.byte_count = 4'd0;
        in_ch.is_last    = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty message, tail counts 0, 3, 4, 5, 7 and 8, all-ones and all-zero
        // words, a tail count above eight, exactly one stripe, and a stripe plus tail.
        send_message(0, 4'd0, 64'd0);
        send_message(0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_message(0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_message(0, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_message(1, 4'd4, 64'd1);
        send_message(2, 4'd7, 64'd1);
        send_message(3, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_message(4, 4'd0, 64'd1);
        send_message(4, 4'd5, 64'd0);

        random_phase(170);
        send_idle_pct = 75;
        recv_idle_pct = 21;
        random_phase(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(170);

        in_ch.valid <= 1'b0;
        while (board.pending_digests.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (board.errors == 0 && board.pending_digests.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/xxh_pkg.sv
rtl/core/xxh_stream_if.sv
rtl/core/xxh_mul.sv
rtl/core/xxh_datapath.sv
rtl/core/xxh_ctrl.sv
rtl/core/xxhash64_stream_hasher.sv
dv/xxh_tb_if.sv
dv/xxhash64_stream_hasher_tb.sv
